@@ design/rfk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfk_pkg
// Shared types and constants for the rtty fsk keyer with ptt.
// ----------------------------------------------------------------------------
package rfk_pkg;

    // field widths
    localparam int CHAR_VALUE_W = 8;
    localparam int MODE_W       = 2;
    localparam int BITS_W       = 4;
    localparam int WAIT_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;

    // default character storage width
    localparam int CHAR_WIDTH_DEF = 8;

    // request modes
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PTT  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_CHAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_FSK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_PTT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_OPEN     = 2'd3;

    // register reset values
    localparam logic [BITS_W-1:0] BITS_PER_CHAR_RST = 4'd5;

    // tick waits
    localparam logic [WAIT_W-1:0] PTT_WAIT  = 4'd8;
    localparam logic [WAIT_W-1:0] BIT_WAIT  = 4'd1;
    localparam logic [WAIT_W-1:0] STOP_WAIT = 4'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [CHAR_VALUE_W-1:0] char_value;
        logic                    ptt_request;
    } in_t;

    typedef struct packed {
        logic key_pin;
        logic ptt_pin;
        logic key_write;
        logic ptt_write;
        logic line_idle;
        logic holding_full;
    } out_t;

    typedef struct packed {
        logic [BITS_W-1:0] bits_per_char;
        logic              invert_fsk;
        logic              invert_ptt;
        logic              port_open;
    } cfg_t;

    // post-update framer status handed to the pin driver
    typedef struct packed {
        logic key_level;
        logic ptt_level;
        logic line_idle;
        logic holding_full;
    } frame_status_t;

endpackage

@@ design/rfk_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfk_cfg
// Configuration register file with a pulse on each port_open write.
// ----------------------------------------------------------------------------
module rfk_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [rfk_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [rfk_pkg::CFG_DATA_W-1:0]   wr_data,
    output rfk_pkg::cfg_t                    cfg,
    output logic                             port_write
);

    rfk_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bits_per_char <= rfk_pkg::BITS_PER_CHAR_RST;
            cfg_reg.invert_fsk    <= 1'b0;
            cfg_reg.invert_ptt    <= 1'b0;
            cfg_reg.port_open     <= 1'b0;
        end else if (wr_en) begin
            case (wr_index)
                rfk_pkg::CFG_BITS_PER_CHAR: cfg_reg.bits_per_char <= wr_data;
                rfk_pkg::CFG_INVERT_FSK:    cfg_reg.invert_fsk    <= wr_data[0];
                rfk_pkg::CFG_INVERT_PTT:    cfg_reg.invert_ptt    <= wr_data[0];
                rfk_pkg::CFG_PORT_OPEN:     cfg_reg.port_open     <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign cfg        = cfg_reg;
    assign port_write = wr_en && (wr_index == rfk_pkg::CFG_PORT_OPEN);

endmodule

@@ design/rfk_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfk_framer
// Holding register, frame sequencer, tick wait and logical ptt level.
// ----------------------------------------------------------------------------
module rfk_framer #(
    parameter int CHAR_WIDTH = rfk_pkg::CHAR_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  rfk_pkg::in_t          item,
    input  rfk_pkg::cfg_t         cfg,
    output rfk_pkg::frame_status_t status
);

    // bits above the 8-bit input always send as zero
    localparam int SHIFT_W = (CHAR_WIDTH < rfk_pkg::CHAR_VALUE_W) ?
                             CHAR_WIDTH : rfk_pkg::CHAR_VALUE_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_STOP
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic                        hold_valid_reg, hold_valid_next;
    logic [SHIFT_W-1:0]          hold_char_reg, hold_char_next;
    logic [SHIFT_W-1:0]          shift_reg, shift_next;
    logic [rfk_pkg::BITS_W-1:0]  bits_left_reg, bits_left_next;
    logic [rfk_pkg::WAIT_W-1:0]  tick_wait_reg, tick_wait_next;
    logic                        key_level_reg, key_level_next;
    logic                        ptt_level_reg, ptt_level_next;
    logic                        idle_reg, idle_next;

    always_comb begin
        phase_next      = phase_reg;
        hold_valid_next = hold_valid_reg;
        hold_char_next  = hold_char_reg;
        shift_next      = shift_reg;
        bits_left_next  = bits_left_reg;
        tick_wait_next  = tick_wait_reg;
        key_level_next  = key_level_reg;
        ptt_level_next  = ptt_level_reg;
        idle_next       = idle_reg;

        if (fire) begin
            case (item.mode)
                rfk_pkg::MODE_TICK: begin
                    if (tick_wait_reg != '0) begin
                        tick_wait_next = tick_wait_reg - 1'b1;
                    end else begin
                        case (phase_reg)
                            PH_DATA: begin
                                key_level_next = shift_reg[0];
                                shift_next     = shift_reg >> 1;
                                bits_left_next = bits_left_reg - 1'b1;
                                if (bits_left_next == '0) begin
                                    phase_next = PH_STOP;
                                end
                                tick_wait_next = rfk_pkg::BIT_WAIT;
                            end
                            PH_STOP: begin
                                key_level_next = 1'b1;
                                tick_wait_next = rfk_pkg::STOP_WAIT;
                                phase_next     = PH_IDLE;
                            end
                            default: begin
                                phase_next = PH_IDLE;
                                if (hold_valid_reg) begin
                                    // start bit; zero count wraps to sixteen bits
                                    shift_next      = hold_char_reg;
                                    hold_valid_next = 1'b0;
                                    bits_left_next  = cfg.bits_per_char;
                                    key_level_next  = 1'b0;
                                    phase_next      = PH_DATA;
                                    tick_wait_next  = rfk_pkg::BIT_WAIT;
                                    idle_next       = 1'b0;
                                end else begin
                                    key_level_next = 1'b1;
                                    idle_next      = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                rfk_pkg::MODE_LOAD: begin
                    hold_char_next  = item.char_value[SHIFT_W-1:0];
                    hold_valid_next = 1'b1;
                end
                rfk_pkg::MODE_PTT: begin
                    if (ptt_level_reg != item.ptt_request) begin
                        ptt_level_next = item.ptt_request;
                        if (item.ptt_request) begin
                            tick_wait_next = rfk_pkg::PTT_WAIT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hold_valid_reg <= 1'b0;
            tick_wait_reg  <= '0;
            key_level_reg  <= 1'b1;
            ptt_level_reg  <= 1'b0;
            idle_reg       <= 1'b1;
        end else begin
            phase_reg      <= phase_next;
            hold_valid_reg <= hold_valid_next;
            tick_wait_reg  <= tick_wait_next;
            key_level_reg  <= key_level_next;
            ptt_level_reg  <= ptt_level_next;
            idle_reg       <= idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_char_reg <= hold_char_next;
        shift_reg     <= shift_next;
        bits_left_reg <= bits_left_next;
    end

    assign status.key_level    = key_level_next;
    assign status.ptt_level    = ptt_level_next;
    assign status.line_idle    = idle_next;
    assign status.holding_full = hold_valid_next;

endmodule

@@ design/rfk_pin_drv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfk_pin_drv
// Pin drive tracking: redrive on change, optional inversion, result build.
// ----------------------------------------------------------------------------
module rfk_pin_drv (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_fire,
    input  logic                  port_write,
    input  rfk_pkg::cfg_t         cfg,
    input  rfk_pkg::frame_status_t status,
    output rfk_pkg::out_t         result
);

    // applied level is known/level; unknown forces the next drive
    logic key_known_reg, key_known_next;
    logic key_app_reg, key_app_next;
    logic ptt_known_reg, ptt_known_next;
    logic ptt_app_reg, ptt_app_next;
    logic key_pin_reg, key_pin_next;
    logic ptt_pin_reg, ptt_pin_next;
    logic key_wr, ptt_wr;

    always_comb begin
        key_known_next = key_known_reg;
        key_app_next   = key_app_reg;
        ptt_known_next = ptt_known_reg;
        ptt_app_next   = ptt_app_reg;
        key_pin_next   = key_pin_reg;
        ptt_pin_next   = ptt_pin_reg;
        key_wr         = 1'b0;
        ptt_wr         = 1'b0;

        if (port_write) begin
            key_known_next = 1'b0;
            ptt_known_next = 1'b0;
        end else if (tick_fire && cfg.port_open) begin
            if (!key_known_reg || (key_app_reg != status.key_level)) begin
                key_known_next = 1'b1;
                key_app_next   = status.key_level;
                key_pin_next   = cfg.invert_fsk ? status.key_level : !status.key_level;
                key_wr         = 1'b1;
            end
            // ptt drops only once the line is idle
            if ((!ptt_known_reg || (ptt_app_reg != status.ptt_level)) &&
                (status.ptt_level || status.line_idle)) begin
                ptt_known_next = 1'b1;
                ptt_app_next   = status.ptt_level;
                ptt_pin_next   = cfg.invert_ptt ? !status.ptt_level : status.ptt_level;
                ptt_wr         = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_known_reg <= 1'b0;
            ptt_known_reg <= 1'b0;
            key_pin_reg   <= 1'b0;
            ptt_pin_reg   <= 1'b0;
        end else begin
            key_known_reg <= key_known_next;
            ptt_known_reg <= ptt_known_next;
            key_pin_reg   <= key_pin_next;
            ptt_pin_reg   <= ptt_pin_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_app_reg <= key_app_next;
        ptt_app_reg <= ptt_app_next;
    end

    assign result.key_pin      = key_pin_next;
    assign result.ptt_pin      = ptt_pin_next;
    assign result.key_write    = key_wr;
    assign result.ptt_write    = ptt_wr;
    assign result.line_idle    = status.line_idle;
    assign result.holding_full = status.holding_full;

endmodule

@@ design/rtty_fsk_keyer_with_ptt_top.sv @@
`timescale 1ns / 1ps
// path: the input register holds a request; its result is registered onto m_data
// throughput: one request per cycle; the only stall is a full result register
// that m_ready has not drained, which holds one request in the input register
// reset: synchronous active-low aresetn empties both registers, restores register
// defaults, idles the line at mark and marks both pins as needing a first drive
// ----------------------------------------------------------------------------
// rtty_fsk_keyer_with_ptt_top
// Half-bit-tick rtty keyer with holding register, ptt wait and pin drive.
// ----------------------------------------------------------------------------
module rtty_fsk_keyer_with_ptt_top #(
    parameter int CHAR_WIDTH = rfk_pkg::CHAR_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rfk_pkg::in_t                   s_data,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output rfk_pkg::out_t                  m_data,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rfk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfk_pkg::CFG_DATA_W-1:0] cfg_data
);

    // input register stage
    logic           in_valid_reg;
    rfk_pkg::in_t   in_data_reg;
    // result register stage
    logic           m_valid_reg;
    rfk_pkg::out_t  m_data_reg;

    logic                   advance;
    logic                   fire;
    logic                   tick_fire;
    logic                   port_write;
    rfk_pkg::cfg_t          cfg;
    rfk_pkg::frame_status_t status;
    rfk_pkg::out_t          result;

    // the held request moves on whenever the result register is free or draining
    assign advance   = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign tick_fire = fire && (in_data_reg.mode == rfk_pkg::MODE_TICK);
    assign s_ready   = !in_valid_reg || advance;

    // configuration always taken; only the user keeps writes to a quiet keyer
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // register file; a port_open write forces both pins to redrive
    rfk_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (cfg_valid && cfg_ready),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .cfg        (cfg),
        .port_write (port_write)
    );

    // frame sequencer: start, data lsb first, stop, plus the ptt wait
    rfk_framer #(
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .cfg     (cfg),
        .status  (status)
    );

    // pins change only on ticks while the port is open
    rfk_pin_drv u_pin_drv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_fire  (tick_fire),
        .port_write (port_write),
        .cfg        (cfg),
        .status     (status),
        .result     (result)
    );

endmodule

@@ design/rfk_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfk_checker
// Port-level checks for the keyer, bound to the top level.
// ----------------------------------------------------------------------------
module rfk_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input rfk_pkg::out_t m_data,
    input logic          cfg_ready
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // with an empty result register the input side never stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request stalled with empty result register");

    // a request taken at the last edge moves on once the result side is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_valid && s_ready && aresetn) && (!m_valid || m_ready) |=> m_valid)
        else $error("request did not reach the result register");

    // configuration writes are never back-pressured
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind rtty_fsk_keyer_with_ptt_top rfk_checker u_rfk_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);
